@@ src/tns_pkg.sv @@
// package for the triadic network statistics core: types, constants
package tns_pkg;

  localparam int unsigned NODES    = 32;
  localparam int unsigned NODE_W   = $clog2(NODES);
  localparam int unsigned WINDOWS  = 3;
  localparam int unsigned ADDR_W   = $clog2(WINDOWS * NODES * NODES);
  localparam int unsigned OUT_W    = 36;
  localparam int unsigned ACC_W    = 48;
  localparam int unsigned CNT_W    = 6;
  localparam logic [ACC_W-1:0] OUT_MAX = {{(ACC_W-OUT_W){1'b0}}, {OUT_W{1'b1}}};
  // ceil(2^32 / 10), exact quotient for dividends below 2^28
  localparam logic [28:0] DIV10_M = 29'd429496730;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  window;
    logic [4:0]  from_node;
    logic [4:0]  to_node;
    logic [15:0] weight;
    logic [4:0]  sender;
    logic [4:0]  receiver;
  } tns_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] twosend_g0;
    logic [OUT_W-1:0] twosend_g1;
    logic [OUT_W-1:0] twosend_g2;
    logic [OUT_W-1:0] tworecv_g0;
    logic [OUT_W-1:0] tworecv_g1;
    logic [OUT_W-1:0] tworecv_g2;
    logic [OUT_W-1:0] sibling_g0;
    logic [OUT_W-1:0] sibling_g1;
    logic [OUT_W-1:0] sibling_g2;
    logic [OUT_W-1:0] cosibling_g0;
    logic [OUT_W-1:0] cosibling_g1;
    logic [OUT_W-1:0] cosibling_g2;
  } tns_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_LAST, ST_DIV, ST_OUT
  } tns_state_t;

endpackage

@@ src/triadic_network_statistics_core.sv @@
// top level of the triadic network statistics core
// Three node-by-node weight matrices (recent, mid, far) sit in one memory of
// 3*NODES*NODES 16-bit words, read one word per cycle through a registered
// read port. After reset a clearing pass writes zero to every word, during
// which no item is taken. A write item goes straight into the memory and
// leaves the core ready for the next item. A query reads twelve words per
// third node (s->h, h->s, r->h, h->r in each window), one per memory cycle,
// over the first n_eff third nodes (node_count capped at NODES); it then waits
// for the last products to settle, runs twelve divides by ten (reciprocal
// multiply on 24-bit halves) and holds the result until it is taken, and no
// new item is taken before that. Products are folded into window-group sums:
// for each third node the cross products of every window pair are added into
// the group of the higher window index of the pair, and summed over h.
module triadic_network_statistics_core
  import tns_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  tns_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output tns_out_t    out_data
);

  logic [15:0] mem [WINDOWS*NODES*NODES];
  logic [15:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic        wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0] wr_data;

  tns_state_t state, state_next;
  logic [5:0]  node_count;
  logic [ADDR_W-1:0] clr_addr;
  logic [4:0]  sender, receiver;
  logic [NODE_W:0] h_cnt;      // third node being read
  logic [3:0]  slot;           // which of twelve words
  logic [3:0]  rslot;          // slot of data now on rd_data
  logic        rvalid;
  logic [5:0]  n_eff;
  logic [15:0] w_buf [12];     // words of the current third node
  logic [ACC_W-1:0] acc [12];  // pattern*3+group
  logic [ACC_W-1:0] prod [12];
  logic        prod_valid;
  logic [3:0]  div_idx;
  logic        div_ph;         // 0 upper half, 1 lower half
  logic [23:0] dq_hi;
  logic [3:0]  dr_hi;
  logic [27:0] dv_in;
  logic [55:0] dv_prod;
  logic [23:0] dv_q;
  logic [3:0]  dv_rem;
  logic [ACC_W-1:0] dv_full;
  logic [OUT_W-1:0] res [12];
  logic        sndr_ok, rcvr_ok;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign n_eff     = (node_count > 6'(NODES)) ? 6'(NODES) : node_count;
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign sndr_ok   = (32'(sender) < NODES);
  assign rcvr_ok   = (32'(receiver) < NODES);

  // slot: window = slot/4, kind = slot%4 (0 s->h, 1 h->s, 2 r->h, 3 h->r)
  always_comb begin
    logic [1:0] wsel;
    logic [4:0] hn;
    wsel = 2'(slot >> 2);
    hn   = h_cnt[4:0];
    case (slot[1:0])
      2'd0:    rd_addr = ADDR_W'((32'(wsel) * NODES + 32'(sender)) * NODES + 32'(hn));
      2'd1:    rd_addr = ADDR_W'((32'(wsel) * NODES + 32'(hn)) * NODES + 32'(sender));
      2'd2:    rd_addr = ADDR_W'((32'(wsel) * NODES + 32'(receiver)) * NODES + 32'(hn));
      default: rd_addr = ADDR_W'((32'(wsel) * NODES + 32'(hn)) * NODES + 32'(receiver));
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    if (state == ST_CLEAR) begin
      wr_en = 1'b1;
    end else if (state == ST_IDLE && in_valid && in_data.opcode == OP_WRITE &&
                 in_data.window < 2'd3) begin
      wr_en   = 1'b1;
      wr_addr = ADDR_W'((32'(in_data.window) * NODES + 32'(in_data.from_node)) * NODES
                        + 32'(in_data.to_node));
      wr_data = in_data.weight;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (32'(clr_addr) == WINDOWS*NODES*NODES-1) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid && in_data.opcode == OP_QUERY)
                  state_next = (n_eff == 6'd0) ? ST_LAST : ST_READ;
      ST_READ:  if (slot == 4'd11 && h_cnt == 6'(n_eff) - 6'd1) state_next = ST_LAST;
      ST_LAST:  if (!rvalid && !prod_valid) state_next = ST_DIV;
      ST_DIV:   if (div_ph && div_idx == 4'd11) state_next = ST_OUT;
      ST_OUT:   if (!out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // cross products of one third node, grouped by max window
  always_comb begin
    logic [15:0] sh [3], hs [3], rh [3], hr [3];
    logic [1:0] g;
    for (int k = 0; k < 12; k++) prod[k] = '0;
    for (int w = 0; w < 3; w++) begin
      sh[w] = sndr_ok ? w_buf[w*4+0] : 16'd0;
      hs[w] = sndr_ok ? w_buf[w*4+1] : 16'd0;
      rh[w] = rcvr_ok ? w_buf[w*4+2] : 16'd0;
      hr[w] = rcvr_ok ? w_buf[w*4+3] : 16'd0;
    end
    for (int l = 0; l < 3; l++)
      for (int m = 0; m < 3; m++) begin
        g = (l > m) ? 2'(l) : 2'(m);
        prod[0+g] = prod[0+g] + ACC_W'(sh[l] * hr[m]);
        prod[3+g] = prod[3+g] + ACC_W'(hs[l] * rh[m]);
        prod[6+g] = prod[6+g] + ACC_W'(hs[l] * hr[m]);
        prod[9+g] = prod[9+g] + ACC_W'(sh[l] * rh[m]);
      end
  end

  // divide by ten: upper 24 bits first, remainder carried into the lower half
  always_comb begin
    dv_in   = div_ph ? {dr_hi, acc[div_idx][23:0]} : {4'd0, acc[div_idx][ACC_W-1:24]};
    dv_prod = 56'(dv_in * DIV10_M);
    dv_q    = dv_prod[55:32];
    dv_rem  = 4'(dv_in[3:0] - dv_q[3:0] * 4'd10);
    dv_full = {dq_hi, dv_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      node_count <= 6'd32;
      clr_addr   <= '0;
      rvalid     <= 1'b0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) node_count <= cfg_data;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      rvalid     <= (state == ST_READ);
      rslot      <= slot;
      prod_valid <= rvalid && rslot == 4'd11;
      if (rvalid) w_buf[rslot] <= rd_data;
      if (prod_valid)
        for (int k = 0; k < 12; k++) acc[k] <= acc[k] + prod[k];
      if (state == ST_IDLE && in_valid && in_data.opcode == OP_QUERY) begin
        sender   <= in_data.sender;
        receiver <= in_data.receiver;
        h_cnt    <= '0;
        slot     <= '0;
        div_idx  <= '0;
        div_ph   <= 1'b0;
        for (int k = 0; k < 12; k++) acc[k] <= '0;
      end
      if (state == ST_READ) begin
        if (slot == 4'd11) begin
          slot  <= '0;
          h_cnt <= h_cnt + 1'b1;
        end else begin
          slot <= slot + 1'b1;
        end
      end
      if (state == ST_DIV) begin
        if (!div_ph) begin
          dq_hi  <= dv_q;
          dr_hi  <= dv_rem;
          div_ph <= 1'b1;
        end else begin
          res[div_idx] <= (dv_full > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(dv_full);
          div_idx      <= div_idx + 1'b1;
          div_ph       <= 1'b0;
        end
      end
      if (state == ST_DIV && div_ph && div_idx == 4'd11) out_valid <= 1'b1;
      else if (state == ST_OUT && !out_stall) out_valid <= 1'b0;
    end
  end

  assign out_data = '{res[0], res[1], res[2], res[3], res[4], res[5],
                      res[6], res[7], res[8], res[9], res[10], res[11]};

endmodule

@@ src/tns_checker.sv @@
// port-level checker for the triadic network statistics core
module tns_props
  import tns_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input tns_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input tns_out_t out_data
);

  // a held result beat keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no new item while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  // a write beat never produces a result next cycle
  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.opcode == OP_WRITE |=> !out_valid)
    else $error("result after write");

endmodule

bind triadic_network_statistics_core tns_props u_tns_props (.*);

@@ sim/tns_checker.sv @@
// checker for the triadic network statistics core: shadow store, path sums, compare
`timescale 1ns / 100ps
module tns_checker
  import tns_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  logic [5:0] cfg_data,
  input  logic     in_valid,
  input  logic     in_stall,
  input  tns_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  tns_out_t out_data,
  output int       errors,
  output int       pending
);

  localparam int NSTAT = 12;

  logic [15:0] weights [WINDOWS][NODES][NODES];
  logic [5:0]  node_limit;
  tns_out_t    stats_due [$];
  string       stat_names [NSTAT] = '{
    "twosend_g0", "twosend_g1", "twosend_g2", "tworecv_g0", "tworecv_g1", "tworecv_g2",
    "sibling_g0", "sibling_g1", "sibling_g2", "cosibling_g0", "cosibling_g1",
    "cosibling_g2"};

  // sums of the four two-path patterns, grouped by the later window of each pair
  function automatic tns_out_t path_stats(logic [4:0] s, logic [4:0] r);
    logic [63:0] acc [4][3];
    logic [63:0] s_to_h, h_to_s, r_to_h, h_to_r, q;
    int          n, g;
    logic [NSTAT*OUT_W-1:0] flat;
    n = (node_limit > NODES) ? NODES : node_limit;
    foreach (acc[p, k]) acc[p][k] = '0;
    for (int l = 0; l < WINDOWS; l++) begin
      for (int m = 0; m < WINDOWS; m++) begin
        g = (l > m) ? l : m;
        for (int h = 0; h < n; h++) begin
          s_to_h = weights[l][s][h];
          h_to_s = weights[l][h][s];
          r_to_h = weights[m][r][h];
          h_to_r = weights[m][h][r];
          acc[0][g] += s_to_h * h_to_r;
          acc[1][g] += h_to_s * r_to_h;
          acc[2][g] += h_to_s * h_to_r;
          acc[3][g] += s_to_h * r_to_h;
        end
      end
    end
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 3; k++) begin
        q = acc[p][k] / 10;
        if (q > 64'(OUT_MAX)) q = 64'(OUT_MAX);
        flat[(NSTAT-1-(p*3+k))*OUT_W +: OUT_W] = q[OUT_W-1:0];
      end
    end
    return tns_out_t'(flat);
  endfunction

  assign pending = stats_due.size();

  always @(posedge clk) begin
    tns_out_t want;
    logic [NSTAT*OUT_W-1:0] w_flat, g_flat;
    if (rst) begin
      foreach (weights[a, b, c]) weights[a][b][c] <= '0;
      node_limit <= 6'd32;
      stats_due.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) node_limit <= cfg_data;
      if (out_valid && !out_stall) begin
        if (stats_due.size() == 0) begin
          if (errors < 10) $display("unexpected result beat at %0t", $realtime);
          errors <= errors + 1;
        end else begin
          want = stats_due.pop_front();
          w_flat = want;
          g_flat = out_data;
          for (int k = 0; k < NSTAT; k++) begin
            if (w_flat[(NSTAT-1-k)*OUT_W +: OUT_W] !== g_flat[(NSTAT-1-k)*OUT_W +: OUT_W]) begin
              if (errors < 10)
                $display("mismatch %s: expected %0d got %0d", stat_names[k],
                         w_flat[(NSTAT-1-k)*OUT_W +: OUT_W],
                         g_flat[(NSTAT-1-k)*OUT_W +: OUT_W]);
              errors <= errors + 1;
              break;
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.opcode == OP_QUERY)
          stats_due.push_back(path_stats(in_data.sender, in_data.receiver));
        else if (in_data.window < WINDOWS)
          weights[in_data.window][in_data.from_node][in_data.to_node] <= in_data.weight;
      end
    end
  end

endmodule

@@ sim/triadic_network_statistics_core_tb.sv @@
// testbench top for the triadic network statistics core: stimulus and verdict
`timescale 1ns / 100ps
module triadic_network_statistics_core_tb;
  import tns_pkg::*;

  localparam int LIMIT = 3000000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [5:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  tns_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  tns_out_t   out_data;
  int         errors, pending;
  int         cycles = 0;
  bit         steady = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  triadic_network_statistics_core u_top (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));

  tns_checker u_chk (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .errors(errors), .pending(pending));

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 20);
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_beat(tns_in_t beat);
    if (!steady && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load(int w, int f, int t, int wt);
    tns_in_t b;
    b = tns_in_t'($urandom);
    b.opcode = OP_WRITE;
    b.window = 2'(w);
    b.from_node = 5'(f);
    b.to_node = 5'(t);
    b.weight = 16'(wt);
    send_beat(b);
  endtask

  task automatic query(int s, int r);
    tns_in_t b;
    b = tns_in_t'($urandom);
    b.opcode = OP_QUERY;
    b.sender = 5'(s);
    b.receiver = 5'(r);
    send_beat(b);
  endtask

  // drain all results, then let trailing write beats settle before the register write
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (450) @(posedge clk);
  endtask

  task automatic set_nodes(logic [5:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // hot nodes collect most of the weight so queries see dense paths
  function automatic int pick_node();
    int k;
    k = $urandom_range(0, 7);
    if ($urandom_range(0, 99) < 70) return (k < 4) ? k : 24 + k;
    return $urandom_range(0, 31);
  endfunction

  function automatic int pick_weight();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 16'hffff;
      default: return $urandom_range(0, 16'hffff);
    endcase
  endfunction

  task automatic random_items(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 45) query(pick_node(), pick_node());
      else load(($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2),
                pick_node(), pick_node(), pick_weight());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    query(0, 31);
    load(0, 0, 31, 16'hffff);
    load(1, 31, 0, 16'hffff);
    load(2, 31, 31, 16'hffff);
    load(2, 0, 0, 16'hffff);
    load(0, 31, 31, 16'h0001);
    load(1, 0, 0, 16'h8000);
    load(3, 0, 31, 16'h1234);
    load(0, 5, 5, 16'h5555);
    load(1, 5, 5, 16'haaaa);
    load(2, 0, 5, 16'h0000);
    query(0, 0);
    query(31, 31);
    query(0, 31);
    query(31, 0);
    query(5, 5);
    query(7, 9);

    random_items(300);
    set_nodes(6'd0);
    random_items(40);
    set_nodes(6'd1);
    random_items(100);
    set_nodes(6'd63);
    steady = 1'b1;
    random_items(200);
    steady = 1'b0;
    set_nodes(6'($urandom_range(2, 31)));
    random_items(260);
    set_nodes(6'd32);
    random_items(300);

    drain();
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/tns_pkg.sv
src/triadic_network_statistics_core.sv
src/tns_checker.sv
sim/tns_checker.sv
sim/triadic_network_statistics_core_tb.sv
